// ===== design/fpn_pkg.sv =====
// Shared types, constants and helpers for the frame peak normalizer.
`default_nettype none

package fpn_pkg;

    localparam int FRAME_MAX = 64;
    localparam int ADDR_W    = $clog2(FRAME_MAX);
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 16;
    localparam int TARGET_W  = 15;
    localparam int PROD_W    = MAG_W + TARGET_W;
    localparam int STEP_W    = $clog2(MAG_W);

    localparam logic [TARGET_W-1:0] TARGET_RESET = 15'd32767;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last_out;
        logic                       cut_short;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_READ,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_OUT
    } fpn_state_t;

    // Magnitude of a two's complement sample; the most negative code maps to 0x8000.
    function automatic logic [MAG_W-1:0] magnitude_of(input logic [SAMPLE_W-1:0] s);
        logic [MAG_W-1:0] m;
        begin
            m = s[SAMPLE_W-1] ? (~s + 16'd1) : s;
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/fpn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fpn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/fpn_div.sv =====
// Restoring serial divider producing one quotient bit per cycle.
`default_nettype none

module fpn_div
    import fpn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [MAG_W-1:0]  divisor,
    output logic                   done,
    output logic      [MAG_W-1:0]  quotient
);

    logic [MAG_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  q_reg;
    logic [MAG_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [MAG_W:0]    shifted;
    logic [MAG_W:0]    diff;
    logic              ge;

    // The quotient is known to fit in MAG_W bits, so the upper dividend bits seed the remainder.
    always_comb
    begin
        shifted = {rem_reg, q_reg[MAG_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(MAG_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend[PROD_W-1:MAG_W]};
            q_reg   <= dividend[MAG_W-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            q_reg   <= {q_reg[MAG_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== design/frame_peak_normalizer.sv =====
// Top level of the frame peak normalizer.
//
// Input items carry one signed 16-bit sample and a last flag. Samples are stored
// in a 64-entry frame RAM while the peak magnitude is tracked. A frame closes on
// an item with the last flag set, or on the 64th sample (then cut_short is set on
// every result of that frame). After closing, in_ready drops and each stored
// sample is emitted in order, scaled to sample * target_peak / peak, truncated
// toward zero. A frame whose peak is zero passes unchanged.
// While filling, in_ready is high and an item is taken whenever in_valid is set.
// Each result passes a RAM read, a multiply, a divider load, 16 iterations of
// the shared serial divider, the capture of the quotient, and the presentation of
// the output register; a stall on out_ready holds the result and the whole
// sequencer. Reset empties the frame, clears the peak and sets target_peak to
// 32767. The user must write the configuration register through cfg_we and
// cfg_wdata only while no frame is being emitted; the block does not enforce it.
`default_nettype none

module frame_peak_normalizer
    import fpn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire in_item_t            in_item,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output out_item_t                out_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire logic                cfg_we,
    input  wire logic [TARGET_W-1:0] cfg_wdata
);

    fpn_state_t          state_reg;
    fpn_state_t          state_next;

    logic [TARGET_W-1:0] target_reg;
    logic [MAG_W-1:0]    peak_reg;
    logic [ADDR_W-1:0]   fill_reg;
    logic [ADDR_W-1:0]   last_idx_reg;
    logic [ADDR_W-1:0]   k_reg;
    logic                cut_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [PROD_W-1:0]   prod_reg;
    out_item_t           out_reg;

    logic                in_acc;
    logic                out_acc;
    logic                closing;
    logic [MAG_W-1:0]    in_mag;
    logic [MAG_W-1:0]    peak_upd;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                div_start;
    logic                div_done;
    logic [MAG_W-1:0]    quotient;
    logic [SAMPLE_W-1:0] scaled;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign closing  = in_item.last_in || (fill_reg == ADDR_W'(FRAME_MAX - 1));
    assign in_mag   = magnitude_of(in_item.sample_in);
    assign peak_upd = (in_mag > peak_reg) ? in_mag : peak_reg;

    fpn_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FRAME_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (in_acc),
        .waddr (fill_reg),
        .wdata (in_item.sample_in),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    fpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (peak_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:  if (in_acc && closing) state_next = ST_READ;
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = (k_reg == last_idx_reg) ? ST_FILL : ST_READ;
                end
            end
            default:  state_next = ST_FILL;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_FILL:  in_ready  = 1'b1;
            ST_START: div_start = 1'b1;
            ST_OUT:   out_valid = 1'b1;
            default:  ;
        endcase
    end

    always_comb
    begin
        if (peak_reg == '0)
        begin
            scaled = sample_reg;
        end
        else if (sample_reg[SAMPLE_W-1])
        begin
            scaled = ~quotient + 16'd1;
        end
        else
        begin
            scaled = quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            target_reg   <= TARGET_RESET;
            peak_reg     <= '0;
            fill_reg     <= '0;
            last_idx_reg <= '0;
            k_reg        <= '0;
            cut_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
            if (in_acc)
            begin
                peak_reg <= peak_upd;
                if (closing)
                begin
                    fill_reg     <= '0;
                    last_idx_reg <= fill_reg;
                    cut_reg      <= !in_item.last_in;
                    k_reg        <= '0;
                end
                else
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (out_acc)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == last_idx_reg)
                begin
                    peak_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            sample_reg <= ram_rdata;
            prod_reg   <= PROD_W'(magnitude_of(ram_rdata)) * PROD_W'(target_reg);
        end
        if (state_reg == ST_DIV && div_done)
        begin
            out_reg.sample_out <= scaled;
            out_reg.last_out   <= (k_reg == last_idx_reg);
            out_reg.cut_short  <= cut_reg;
        end
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

// ===== design/fpn_checker.sv =====
// Port-level checker for the frame peak normalizer, bound to the top level.
`default_nettype none

module fpn_checker
    import fpn_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire in_item_t  in_item,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire out_item_t out_item,
    input wire logic      out_valid,
    input wire logic      out_ready
);

    // The block never takes an item while it is emitting a frame.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid high together");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // Delivering the final result of a frame reopens the input.
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_item.last_out |=> in_ready && !out_valid)
        else $error("input not reopened after the final result");

    // An item carrying the last flag closes the frame at once.
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.last_in |=> !in_ready)
        else $error("frame did not close on the last flag");

endmodule

bind frame_peak_normalizer fpn_checker u_fpn_checker (.*);

`default_nettype wire
